@@ rtl/core/sdr_pkg.sv @@
// ----------------------------------------------------------------------------
// sdr_pkg: shared types and constants of the scheduled dimmer
// Operation codes, field widths, limits and the item structs of both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdr_pkg;

  // Field widths
  localparam int unsigned OP_W   = 3;
  localparam int unsigned TIME_W = 11;
  localparam int unsigned LVL_W  = 10;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned NCH    = 4;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLOCK  = 3'd0;
  localparam logic [OP_W-1:0] OP_RAMP   = 3'd1;
  localparam logic [OP_W-1:0] OP_WR_OFF = 3'd2;
  localparam logic [OP_W-1:0] OP_WR_ON  = 3'd3;
  localparam logic [OP_W-1:0] OP_MANUAL = 3'd4;

  // Limits
  localparam logic [TIME_W-1:0] END_MARK   = 11'd1439;
  localparam logic [TIME_W-1:0] TIME_EMPTY = 11'd2047;
  localparam logic [4:0]        HOUR_MAX   = 5'd23;
  localparam logic [5:0]        MIN_MAX    = 6'd59;
  localparam logic [LVL_W-1:0]  PCT_MAX    = 10'd100;
  localparam logic [LVL_W-1:0]  DUTY_MAX   = 10'd1000;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [2:0]        entry_index;
    logic [TIME_W-1:0] entry_time;
    logic              power_on;
    logic [LVL_W-1:0]  level_ch0;
    logic [LVL_W-1:0]  level_ch1;
    logic [LVL_W-1:0]  level_ch2;
    logic [LVL_W-1:0]  level_ch3;
  } in_item_t;

  typedef struct packed {
    logic [LVL_W-1:0] duty_ch0;
    logic [LVL_W-1:0] duty_ch1;
    logic [LVL_W-1:0] duty_ch2;
    logic [LVL_W-1:0] duty_ch3;
    logic             lamp_on;
  } out_item_t;

  // Percent (0..100) to duty (0..1000): p*8 + p*2
  function automatic logic [LVL_W-1:0] pct_to_duty(input logic [PCT_W-1:0] p);
    logic [LVL_W-1:0] pe;
    pe = LVL_W'(p);
    return (pe << 3) + (pe << 1);
  endfunction

endpackage

@@ rtl/core/scheduled_dimmer_with_ramp_core.sv @@
// ----------------------------------------------------------------------------
// scheduled_dimmer_with_ramp_core: scheduled four-channel lamp dimmer
// Daily turn-off/turn-on lists held in RAM, ramped PWM duties per channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one operation
//   per item: clock reading, ramp tick, turn-off entry write, turn-on entry
//   write or manual set. Output channel (out_valid_o / out_stall_i /
//   out_item_o) returns exactly one item per input item: the four duties and
//   the lamp power flag as they stand after that input has been applied.
//   A clock reading with a valid time and second zero scans both
//   lists, one entry a cycle through the RAM read port, and gives its result
//   when the last entry has been evaluated; the next item is taken after that.
//   All other items give their result in the cycle after acceptance, and a new
//   item may follow every cycle while the output is taken.
//   The result sits in one output register; while the receiver stalls it,
//   the block holds the item and takes no new input.
//   Reset empties both lists (per-entry valid bits cleared at once), switches
//   the lamp off and sets all levels and duties to zero; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scheduled_dimmer_with_ramp_core #(
  parameter int unsigned CHANNELS = 4,
  parameter int unsigned ENTRIES  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sdr_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sdr_pkg::out_item_t  out_item_o
);

  localparam int unsigned AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned PCTS  = sdr_pkg::NCH * sdr_pkg::PCT_W;
  localparam int unsigned ON_W  = sdr_pkg::TIME_W + PCTS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // Sequencer and scan state
  logic                       st_q, st_d;
  logic [AW-1:0]              rd_addr_q, rd_addr_d;
  logic                       iss_q, iss_d;
  logic                       ev_vld_q, ev_last_q;
  logic                       off_rv_q, on_rv_q;
  logic                       off_open_q, on_open_q, off_open_n, on_open_n;
  logic                       off_hit_q, on_hit_q, off_hit_n, on_hit_n;
  logic [PCTS-1:0]            hit_pct_q, hit_pct_n;
  logic [sdr_pkg::TIME_W-1:0] tm_q, tm_d;
  logic [ENTRIES-1:0]         off_vld_q, on_vld_q;

  // Lamp state
  logic                       pwr_q, pwr_d;
  logic [sdr_pkg::LVL_W-1:0]  lvl_q  [sdr_pkg::NCH];
  logic [sdr_pkg::LVL_W-1:0]  lvl_d  [sdr_pkg::NCH];
  logic [sdr_pkg::LVL_W-1:0]  duty_q [sdr_pkg::NCH];
  logic [sdr_pkg::LVL_W-1:0]  duty_d [sdr_pkg::NCH];

  // Output register
  logic                       out_vld_q;
  sdr_pkg::out_item_t         out_q, out_d;

  // RAM ports
  logic                       off_we, on_we, rd_en;
  logic [AW-1:0]              wr_addr;
  logic [sdr_pkg::TIME_W-1:0] off_rdata;
  logic [ON_W-1:0]            on_rdata, on_wdata;

  logic                       in_acc, clk_ok, start_scan, scan_fin, done_now, idx_ok;
  logic [sdr_pkg::LVL_W-1:0]  lvl_in [sdr_pkg::NCH];
  logic [sdr_pkg::PCT_W-1:0]  pct_in [sdr_pkg::NCH];
  logic [sdr_pkg::TIME_W-1:0] off_t, on_t;
  logic [PCTS-1:0]            on_pct;
  logic [sdr_pkg::LVL_W-1:0]  tgt;

  // Handshake
  assign in_stall_o  = (st_q != ST_IDLE) || (out_vld_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  assign clk_ok = (in_item_i.hour <= sdr_pkg::HOUR_MAX) &&
                  (in_item_i.minute <= sdr_pkg::MIN_MAX) &&
                  (in_item_i.second == 6'd0);
  assign start_scan = in_acc && (in_item_i.operation == sdr_pkg::OP_CLOCK) && clk_ok;
  assign scan_fin   = (st_q == ST_SCAN) && ev_vld_q && ev_last_q;
  assign done_now   = (in_acc && !start_scan) || scan_fin;
  assign tm_d       = sdr_pkg::TIME_W'(in_item_i.hour) * 11'd60 +
                      sdr_pkg::TIME_W'(in_item_i.minute);

  assign lvl_in[0] = in_item_i.level_ch0;
  assign lvl_in[1] = in_item_i.level_ch1;
  assign lvl_in[2] = in_item_i.level_ch2;
  assign lvl_in[3] = in_item_i.level_ch3;

  // Clamp percents of a turn-on entry to 100
  always_comb begin
    for (int c = 0; c < sdr_pkg::NCH; c++) begin
      pct_in[c] = (lvl_in[c] > sdr_pkg::PCT_MAX) ? sdr_pkg::PCT_MAX[sdr_pkg::PCT_W-1:0]
                                                 : lvl_in[c][sdr_pkg::PCT_W-1:0];
    end
  end

  // Table write port
  assign idx_ok   = int'(in_item_i.entry_index) < ENTRIES;
  assign wr_addr  = AW'(in_item_i.entry_index);
  assign off_we   = in_acc && (in_item_i.operation == sdr_pkg::OP_WR_OFF) && idx_ok;
  assign on_we    = in_acc && (in_item_i.operation == sdr_pkg::OP_WR_ON) && idx_ok;
  assign on_wdata = {in_item_i.entry_time, pct_in[3], pct_in[2], pct_in[1], pct_in[0]};
  assign rd_en    = (st_q == ST_SCAN) && iss_q;

  sdr_ram #(
    .WIDTH (sdr_pkg::TIME_W),
    .DEPTH (ENTRIES)
  ) u_off_ram (
    .clk_i   (clk_i),
    .we_i    (off_we),
    .waddr_i (wr_addr),
    .wdata_i (in_item_i.entry_time),
    .re_i    (rd_en),
    .raddr_i (rd_addr_q),
    .rdata_o (off_rdata)
  );

  sdr_ram #(
    .WIDTH (ON_W),
    .DEPTH (ENTRIES)
  ) u_on_ram (
    .clk_i   (clk_i),
    .we_i    (on_we),
    .waddr_i (wr_addr),
    .wdata_i (on_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr_q),
    .rdata_o (on_rdata)
  );

  // Evaluate the entry read last cycle; never-written entries read as empty
  assign off_t  = off_rv_q ? off_rdata : sdr_pkg::TIME_EMPTY;
  assign on_t   = on_rv_q ? on_rdata[ON_W-1 -: sdr_pkg::TIME_W] : sdr_pkg::TIME_EMPTY;
  assign on_pct = on_rv_q ? on_rdata[PCTS-1:0] : '0;

  always_comb begin
    off_open_n = off_open_q;
    off_hit_n  = off_hit_q;
    on_open_n  = on_open_q;
    on_hit_n   = on_hit_q;
    hit_pct_n  = hit_pct_q;
    if (ev_vld_q && off_open_q) begin
      if (off_t > sdr_pkg::END_MARK) begin
        off_open_n = 1'b0;
      end else if (off_t == tm_q) begin
        off_hit_n  = 1'b1;
        off_open_n = 1'b0;
      end
    end
    if (ev_vld_q && on_open_q) begin
      if (on_t > sdr_pkg::END_MARK) begin
        on_open_n = 1'b0;
      end else if (on_t == tm_q) begin
        on_hit_n  = 1'b1;
        on_open_n = 1'b0;
        hit_pct_n = on_pct;
      end
    end
  end

  // Sequencer: issue one read a cycle until the last entry
  always_comb begin
    st_d      = st_q;
    rd_addr_d = rd_addr_q;
    iss_d     = iss_q;
    if (start_scan) begin
      st_d      = ST_SCAN;
      rd_addr_d = '0;
      iss_d     = 1'b1;
    end else if (st_q == ST_SCAN) begin
      if (iss_q) begin
        rd_addr_d = rd_addr_q + AW'(1);
        iss_d     = (rd_addr_q != LAST_ADDR);
      end
      if (scan_fin) begin
        st_d = ST_IDLE;
      end
    end
  end

  // Lamp state update
  always_comb begin
    pwr_d  = pwr_q;
    lvl_d  = lvl_q;
    duty_d = duty_q;
    tgt    = '0;
    if (in_acc) begin
      case (in_item_i.operation)
        sdr_pkg::OP_RAMP: begin
          for (int c = 0; c < sdr_pkg::NCH; c++) begin
            if (c < CHANNELS) begin
              tgt = pwr_q ? lvl_q[c] : '0;
              if ({1'b0, duty_q[c]} + 11'd1 < {1'b0, tgt}) begin
                duty_d[c] = duty_q[c] + 10'd1;
              end else if ({1'b0, duty_q[c]} > {1'b0, tgt} + 11'd1) begin
                duty_d[c] = duty_q[c] - 10'd1;
              end
            end
          end
        end
        sdr_pkg::OP_MANUAL: begin
          pwr_d = in_item_i.power_on;
          for (int c = 0; c < sdr_pkg::NCH; c++) begin
            if (c < CHANNELS) begin
              lvl_d[c] = (lvl_in[c] > sdr_pkg::DUTY_MAX) ? sdr_pkg::DUTY_MAX : lvl_in[c];
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (scan_fin) begin
      if (on_hit_n) begin
        pwr_d = 1'b1;
        for (int c = 0; c < sdr_pkg::NCH; c++) begin
          if (c < CHANNELS) begin
            lvl_d[c] = sdr_pkg::pct_to_duty(hit_pct_n[c*sdr_pkg::PCT_W +: sdr_pkg::PCT_W]);
          end
        end
      end else if (off_hit_n) begin
        pwr_d = 1'b0;
      end
    end
  end

  // Result item from the state after this input
  always_comb begin
    out_d.duty_ch0 = duty_d[0];
    out_d.duty_ch1 = duty_d[1];
    out_d.duty_ch2 = duty_d[2];
    out_d.duty_ch3 = duty_d[3];
    out_d.lamp_on  = pwr_d;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      rd_addr_q  <= '0;
      iss_q      <= 1'b0;
      ev_vld_q   <= 1'b0;
      ev_last_q  <= 1'b0;
      off_rv_q   <= 1'b0;
      on_rv_q    <= 1'b0;
      off_open_q <= 1'b0;
      on_open_q  <= 1'b0;
      off_hit_q  <= 1'b0;
      on_hit_q   <= 1'b0;
      off_vld_q  <= '0;
      on_vld_q   <= '0;
      pwr_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int c = 0; c < sdr_pkg::NCH; c++) begin
        lvl_q[c]  <= '0;
        duty_q[c] <= '0;
      end
    end else begin
      st_q      <= st_d;
      rd_addr_q <= rd_addr_d;
      iss_q     <= iss_d;
      ev_vld_q  <= rd_en;
      ev_last_q <= rd_en && (rd_addr_q == LAST_ADDR);
      if (rd_en) begin
        off_rv_q <= off_vld_q[rd_addr_q];
        on_rv_q  <= on_vld_q[rd_addr_q];
      end
      if (start_scan) begin
        off_open_q <= 1'b1;
        on_open_q  <= 1'b1;
        off_hit_q  <= 1'b0;
        on_hit_q   <= 1'b0;
      end else begin
        off_open_q <= off_open_n;
        on_open_q  <= on_open_n;
        off_hit_q  <= off_hit_n;
        on_hit_q   <= on_hit_n;
      end
      if (off_we) begin
        off_vld_q[wr_addr] <= 1'b1;
      end
      if (on_we) begin
        on_vld_q[wr_addr] <= 1'b1;
      end
      pwr_q  <= pwr_d;
      lvl_q  <= lvl_d;
      duty_q <= duty_d;
      if (done_now) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (start_scan) begin
      tm_q <= tm_d;
    end
    hit_pct_q <= hit_pct_n;
    if (done_now) begin
      out_q <= out_d;
    end
  end

  // Checks
  a_scan_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_fin |=> out_vld_q)
    else $error("scan finished without a result item");

  a_no_accept_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCAN) |-> !in_acc)
    else $error("item accepted during a schedule scan");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |-> !done_now)
    else $error("result item overwritten while stalled");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (duty_q[0] <= sdr_pkg::DUTY_MAX) && (duty_q[1] <= sdr_pkg::DUTY_MAX) &&
    (duty_q[2] <= sdr_pkg::DUTY_MAX) && (duty_q[3] <= sdr_pkg::DUTY_MAX))
    else $error("duty above full scale");

  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_scan |=> (st_q == ST_SCAN) && iss_q && (rd_addr_q == '0))
    else $error("scan did not start at entry zero");

endmodule

@@ rtl/core/sdr_ram.sv @@
// ----------------------------------------------------------------------------
// sdr_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdr_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
